// File: hdl/dq_pkg.sv
// Package for the double-ended queue.
// Holds the word width, request, status and state codes. No dependencies.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } stat_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_e;

endpackage

// File: hdl/dq_ram.sv
// Ring store of the double-ended queue: one write port, two registered read ports.
// Depends on dq_pkg for the word width.
`timescale 1ns / 1ps

module dq_ram
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [WORD_W-1:0]          wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_b_i,
  output logic [WORD_W-1:0]          rd_data_a_o,
  output logic [WORD_W-1:0]          rd_data_b_o
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule

// File: hdl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words kept in a ring store.
// Depends on dq_pkg and dq_ram.
//
// Each accepted request updates the front index and entry count and writes a
// pushed word in the cycle it is taken; the new front and back words are read
// from the store in that same cycle and are registered there, and the result
// is loaded into the output register in the response state once that register
// is free. The block takes no new request until then. The store needs no
// clearing pass after reset.
`timescale 1ns / 1ps

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      req_type_i,
  input  logic signed [WORD_W-1:0]        push_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [WORD_W-1:0]        front_value_o,
  output logic signed [WORD_W-1:0]        back_value_o,
  output logic [$clog2(DEPTH+1)-1:0]      entry_count_o,
  output logic                            is_empty_o,
  output logic [1:0]                      status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  state_e state_q, state_d;

  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  stat_e             stat_q, stat_d;
  logic              fwd_front_q, fwd_front_d;
  logic              fwd_back_q, fwd_back_d;
  logic [WORD_W-1:0] fwd_word_q;

  logic              accept;
  logic              load_out;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     back_addr;
  logic [WORD_W-1:0] rd_front, rd_back;

  logic              out_valid_q;
  logic [WORD_W-1:0] front_val_q, back_val_q;
  logic [CW-1:0]     count_out_q;
  logic              empty_q;
  stat_e             stat_out_q;

  // Request execution: pointer update, write and read addresses
  always_comb begin
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] back_sum;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] front_dec;
    logic          full;
    logic          empty;

    full      = (count_q == CW'(DEPTH));
    empty     = (count_q == '0);
    front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
    front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
    tail_sum  = SW'(front_q) + SW'(count_q);
    if (tail_sum >= DEPTH_S) begin
      tail_sum = tail_sum - DEPTH_S;
    end

    front_d = front_q;
    count_d = count_q;
    stat_d  = STAT_OK;
    wr_en   = 1'b0;
    wr_addr = tail_sum[AW-1:0];

    case (req_e'(req_type_i))
      REQ_PUSH_BACK: begin
        if (full) begin
          stat_d = STAT_PUSH_FULL;
        end else begin
          wr_en   = accept;
          count_d = count_q + CW'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          stat_d = STAT_PUSH_FULL;
        end else begin
          wr_en   = accept;
          wr_addr = front_dec;
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          stat_d = STAT_POP_EMPTY;
        end else begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          stat_d = STAT_POP_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      default: begin
      end
    endcase

    // Back position is unused when the queue ends up empty
    back_sum = SW'(front_d) + SW'(count_d) - SW'(1);
    if (back_sum >= DEPTH_S) begin
      back_sum = back_sum - DEPTH_S;
    end
    back_addr = back_sum[AW-1:0];

    fwd_front_d = wr_en && (wr_addr == front_d);
    fwd_back_d  = wr_en && (wr_addr == back_addr);
  end

  dq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (push_value_i),
    .rd_en_i     (accept),
    .rd_addr_a_i (front_d),
    .rd_addr_b_i (back_addr),
    .rd_data_a_o (rd_front),
    .rd_data_b_o (rd_back)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        front_q <= front_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q      <= stat_d;
      fwd_front_q <= fwd_front_d;
      fwd_back_q  <= fwd_back_d;
      fwd_word_q  <= push_value_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      count_out_q <= count_q;
      empty_q     <= (count_q == '0);
      stat_out_q  <= stat_q;
      if (count_q == '0) begin
        front_val_q <= '1;
        back_val_q  <= '1;
      end else begin
        front_val_q <= fwd_front_q ? fwd_word_q : rd_front;
        back_val_q  <= fwd_back_q ? fwd_word_q : rd_back;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_value_o = front_val_q;
  assign back_value_o  = back_val_q;
  assign entry_count_o = count_out_q;
  assign is_empty_o    = empty_q;
  assign status_o      = stat_out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RESP))
    else $error("accepted word not followed by response cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_PUSH_FULL) |-> (entry_count_o == CW'(DEPTH)))
    else $error("push dropped while not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_POP_EMPTY) |->
      (is_empty_o && front_value_o == '1 && back_value_o == '1))
    else $error("pop on empty reported a non-empty queue");

endmodule
